@@ src/udiv_pkg.sv @@
package udiv_pkg;

  // operand and result widths
  localparam int unsigned DataWidth = 64;
  localparam int unsigned CountWidth = $clog2(DataWidth);
  localparam int unsigned InDataWidth = 3 * DataWidth;
  localparam int unsigned OutDataWidth = 2 * DataWidth;
  localparam int unsigned OutUserWidth = 2;

  // bit positions of the result flags in m_tuser
  localparam int unsigned UserZeroBit = 0;
  localparam int unsigned UserOverflowBit = 1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;      // take a new item from the input
    logic step;      // one restoring division step
    logic swap;      // with step: end of the upper-half reduction, bring in the lower half
    logic out_load;  // move the finished result into the output register
  } udiv_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic div_zero;  // divisor of the offered item is zero
    logic skip_mod;  // upper half already below the divisor
  } udiv_status_t;

endpackage

@@ src/udiv_ctrl.sv @@
module udiv_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  input  udiv_pkg::udiv_status_t status,
  output udiv_pkg::udiv_cmd_t    cmd
);
  import udiv_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MOD  = 4'b0010,
    ST_LOW  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  localparam logic [CountWidth-1:0] LastStep = CountWidth'(DataWidth - 1);

  state_t                state;
  state_t                state_next;
  logic [CountWidth-1:0] cnt;
  logic [CountWidth-1:0] cnt_next;
  logic                  out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cnt_next = cnt;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load = 1'b1;
          cnt_next = '0;
          if (status.div_zero) begin
            state_next = ST_DONE;
          end else if (status.skip_mod) begin
            state_next = ST_LOW;
          end else begin
            state_next = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        cmd.step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == LastStep) begin
          cmd.swap = 1'b1;
          state_next = ST_LOW;
        end
      end
      ST_LOW: begin
        cmd.step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == LastStep) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state, step counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

@@ src/udiv_datapath.sv @@
module udiv_datapath (
  input  logic                                 clk,
  input  logic [udiv_pkg::DataWidth-1:0]       dividend_upper,
  input  logic [udiv_pkg::DataWidth-1:0]       dividend_lower,
  input  logic [udiv_pkg::DataWidth-1:0]       divisor_value,
  input  udiv_pkg::udiv_cmd_t                  cmd,
  output udiv_pkg::udiv_status_t               status,
  output logic [udiv_pkg::DataWidth-1:0]       quotient_out,
  output logic [udiv_pkg::DataWidth-1:0]       remainder_out,
  output logic                                 zero_divisor,
  output logic                                 quotient_overflow
);
  import udiv_pkg::*;

  logic [DataWidth-1:0] rem;
  logic [DataWidth-1:0] shin;
  logic [DataWidth-1:0] quo;
  logic [DataWidth-1:0] dvs;
  logic [DataWidth-1:0] lower;
  logic                 zero_flag;
  logic                 ovf_flag;

  logic [DataWidth-1:0] rem_shift;
  logic [DataWidth:0]   diff;
  logic                 take;

  // status on the offered item
  assign status.div_zero = (divisor_value == '0);
  assign status.skip_mod = (dividend_upper < divisor_value);

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_shift = {rem[DataWidth-2:0], shin[DataWidth-1]};
  assign diff = {rem[DataWidth-1], rem_shift} - {1'b0, dvs};
  assign take = !diff[DataWidth];

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dvs <= divisor_value;
      lower <= dividend_lower;
      quo <= '0;
      zero_flag <= status.div_zero;
      ovf_flag <= !status.div_zero && !status.skip_mod;
      if (status.skip_mod) begin
        rem <= dividend_upper;
        shin <= dividend_lower;
      end else begin
        rem <= '0;
        shin <= dividend_upper;
      end
    end else if (cmd.step) begin
      rem <= take ? diff[DataWidth-1:0] : rem_shift;
      if (cmd.swap) begin
        shin <= lower;
        quo <= '0;
      end else begin
        shin <= {shin[DataWidth-2:0], 1'b0};
        quo <= {quo[DataWidth-2:0], take};
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      quotient_out <= zero_flag ? '1 : quo;
      remainder_out <= zero_flag ? '0 : rem;
      zero_divisor <= zero_flag;
      quotient_overflow <= ovf_flag;
    end
  end

endmodule

@@ src/unsigned_divide_128_by_64.sv @@
// Unsigned 128-by-64-bit divider.
// Input item on s_tvalid/s_tready/s_tdata: dividend upper half, dividend lower
// half and divisor, 64 bits each. Result item on m_tvalid/m_tready/m_tdata:
// low 64 bits of the quotient and the remainder; m_tuser carries the
// zero-divisor flag and the quotient-overflow flag.
// A zero divisor gives an all-ones quotient, a zero remainder and the zero
// flag. The overflow flag is set when the divisor is nonzero and the upper half
// is not below it. Work after an input accept: when the upper half is below
// the divisor, 64 restoring steps, one quotient bit per cycle in a single
// 65-bit subtractor, then the hand-over; when it is not, 64 more steps first
// reduce the upper half modulo the divisor; on a zero divisor, straight to the
// hand-over. The next item can be accepted in the cycle after the hand-over.
// One item is in work at a time; s_tready is high only while the block is
// free. The result sits in an output register, so the next item is accepted
// and worked on while a result waits; a stalled receiver holds only the final
// hand-over into that register.
// Synchronous reset clears the controller and drops m_tvalid; items in work
// are lost.
module unsigned_divide_128_by_64 (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // dividend_upper [63:0], dividend_lower [127:64], divisor_value [191:128]
  input  logic [udiv_pkg::InDataWidth-1:0]     s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // quotient_out [63:0], remainder_out [127:64]
  output logic [udiv_pkg::OutDataWidth-1:0]    m_tdata,
  // zero_divisor [0], quotient_overflow [1]
  output logic [udiv_pkg::OutUserWidth-1:0]    m_tuser
);
  import udiv_pkg::*;

  udiv_cmd_t            cmd;
  udiv_status_t         status;
  logic [DataWidth-1:0] quotient_out;
  logic [DataWidth-1:0] remainder_out;
  logic                 zero_divisor;
  logic                 quotient_overflow;

  // sequencer
  udiv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // shift-subtract datapath and output register
  udiv_datapath u_dp (
    .clk               (clk),
    .dividend_upper    (s_tdata[DataWidth-1:0]),
    .dividend_lower    (s_tdata[2*DataWidth-1:DataWidth]),
    .divisor_value     (s_tdata[3*DataWidth-1:2*DataWidth]),
    .cmd               (cmd),
    .status            (status),
    .quotient_out      (quotient_out),
    .remainder_out     (remainder_out),
    .zero_divisor      (zero_divisor),
    .quotient_overflow (quotient_overflow)
  );

  assign m_tdata = {remainder_out, quotient_out};
  assign m_tuser[UserZeroBit] = zero_divisor;
  assign m_tuser[UserOverflowBit] = quotient_overflow;

endmodule

@@ src/udiv_checker.sv @@
module udiv_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 s_tvalid,
  input logic                                 s_tready,
  input logic [udiv_pkg::InDataWidth-1:0]     s_tdata,
  input logic                                 m_tvalid,
  input logic                                 m_tready,
  input logic [udiv_pkg::OutDataWidth-1:0]    m_tdata,
  input logic [udiv_pkg::OutUserWidth-1:0]    m_tuser
);
  import udiv_pkg::*;

  // a waiting result stays valid
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result item dropped while stalled");

  // a waiting result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result item changed while stalled");

  // zero divisor gives all-ones quotient and zero remainder
  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[UserZeroBit] |->
      m_tdata[DataWidth-1:0] == '1 && m_tdata[OutDataWidth-1:DataWidth] == '0)
    else $error("bad result for zero divisor");

  // the two flags never come together
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[UserZeroBit] && m_tuser[UserOverflowBit]))
    else $error("zero and overflow flags both set");

  // an accepted item keeps the block busy the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after accept");

endmodule

bind unsigned_divide_128_by_64 udiv_checker u_udiv_checker (.*);
